### rtl/drp_pkg.sv
package drp_pkg;

  // Image geometry.
  localparam int DECIMATION = 8;
  localparam int MAX_DIM    = 4096;

  // Field widths.
  localparam int ROW_W   = 12;
  localparam int COL_W   = 12;
  localparam int RAW_W   = 16;
  localparam int COLOR_W = 8;

  // Configuration register widths.
  localparam int F_W       = 16;
  localparam int B_W       = 17;
  localparam int C_W       = 16;
  localparam int SCALE_W   = 16;
  localparam int MIND_W    = 11;
  localparam int INV_W     = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  // Datapath widths.
  localparam int FRAC_D    = 12;                    // fraction bits of the scaled disparity
  localparam int PROD_W    = RAW_W + SCALE_W;       // raw code times scale
  localparam int SUM_W     = PROD_W + 2;            // signed disparity with offset
  localparam int DEN_W     = PROD_W + 1;            // positive disparity, Q.12
  localparam int DIFF_W    = C_W + 1;               // signed offset from the image center
  localparam int MAG_W     = C_W;                   // magnitude of that offset
  localparam int NUM_SHIFT = 8;
  localparam int NUM_W     = MAG_W + B_W + NUM_SHIFT;
  localparam int Q_BITS    = 31;                    // quotient bits below saturation
  localparam int HI_W      = NUM_W - Q_BITS;
  localparam int DIV_LAT   = Q_BITS + 1;            // divider stages
  localparam int OUT_W     = 32;
  localparam int Z_W       = 31;

  // Divider lanes.
  localparam int LANES  = 3;
  localparam int LANE_Z = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;

  // Saturation limits of a signed Q16.16 coordinate.
  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  // Reset values of the configuration registers.
  localparam logic [F_W-1:0]     RST_FOCAL    = 16'd16384;
  localparam logic [B_W-1:0]     RST_BASELINE = 17'd15729;
  localparam logic [C_W-1:0]     RST_CCOL     = 16'd10240;
  localparam logic [C_W-1:0]     RST_CROW     = 16'd7680;
  localparam logic [SCALE_W-1:0] RST_SCALE    = 16'd64;
  localparam logic [MIND_W-1:0]  RST_MIND     = 11'd0;
  localparam logic [INV_W-1:0]   RST_INVALID  = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL    = 3'd0,
    CFG_BASELINE = 3'd1,
    CFG_CCOL     = 3'd2,
    CFG_CROW     = 3'd3,
    CFG_SCALE    = 3'd4,
    CFG_MIND     = 3'd5,
    CFG_INVALID  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [F_W-1:0]     focal_length;
    logic [B_W-1:0]     baseline;
    logic [C_W-1:0]     center_col;
    logic [C_W-1:0]     center_row;
    logic [SCALE_W-1:0] disparity_scale;
    logic [MIND_W-1:0]  min_disparity;
    logic [INV_W-1:0]   invalid_code;
  } cfg_t;

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } side_t;

  // Divider operands: one numerator per lane and a shared denominator.
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]            den;
  } op_t;

endpackage

### rtl/drp_front.sv
module drp_front
  import drp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [ROW_W-1:0]   in_pixel_row,
  input  logic [COL_W-1:0]   in_pixel_col,
  input  logic [RAW_W-1:0]   in_disparity_raw,
  input  logic [COLOR_W-1:0] in_red,
  input  logic [COLOR_W-1:0] in_green,
  input  logic [COLOR_W-1:0] in_blue,
  input  cfg_t               cfg,
  output logic               front_valid,
  output side_t              front_side,
  output op_t                front_op
);

  // Stage A registers.
  logic                     a_valid_r;
  logic                     a_pass_r;
  logic [PROD_W-1:0]        a_prod_r;
  logic signed [DIFF_W-1:0] a_dx_r;
  logic signed [DIFF_W-1:0] a_dy_r;
  logic [COLOR_W-1:0]       a_red_r;
  logic [COLOR_W-1:0]       a_green_r;
  logic [COLOR_W-1:0]       a_blue_r;

  // Stage B registers.
  logic  b_valid_r;
  side_t b_side_r;
  op_t   b_op_r;

  logic                     a_pass_nxt;
  logic [PROD_W-1:0]        a_prod_nxt;
  logic signed [DIFF_W-1:0] a_dx_nxt;
  logic signed [DIFF_W-1:0] a_dy_nxt;

  logic signed [SUM_W-1:0]  b_sum;
  logic signed [SUM_W-1:0]  b_mind;
  logic                     b_keep;
  logic [MAG_W-1:0]         b_mag_x;
  logic [MAG_W-1:0]         b_mag_y;
  logic [F_W+B_W-1:0]       b_fb;
  logic [MAG_W+B_W-1:0]     b_xb;
  logic [MAG_W+B_W-1:0]     b_yb;
  op_t                      b_op_nxt;
  side_t                    b_side_nxt;

  // Stage A: screen the pixel, scale the raw code, offset from the center.
  always_comb begin
    a_pass_nxt = (32'(in_pixel_row) < MAX_DIM) && (32'(in_pixel_col) < MAX_DIM) &&
                 ((in_pixel_row % DECIMATION) == 0) && ((in_pixel_col % DECIMATION) == 0) &&
                 (in_disparity_raw != '0) && (in_disparity_raw != cfg.invalid_code);
    a_prod_nxt = PROD_W'(in_disparity_raw) * PROD_W'(cfg.disparity_scale);
    a_dx_nxt   = $signed({1'b0, in_pixel_col, 4'b0000}) - $signed({1'b0, cfg.center_col});
    a_dy_nxt   = $signed({1'b0, in_pixel_row, 4'b0000}) - $signed({1'b0, cfg.center_row});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pass_r  <= a_pass_nxt;
      a_prod_r  <= a_prod_nxt;
      a_dx_r    <= a_dx_nxt;
      a_dy_r    <= a_dy_nxt;
      a_red_r   <= in_red;
      a_green_r <= in_green;
      a_blue_r  <= in_blue;
    end
  end

  // Stage B: add the disparity offset, form the three numerators.
  always_comb begin
    b_mind  = {{(SUM_W-MIND_W-FRAC_D){cfg.min_disparity[MIND_W-1]}},
               cfg.min_disparity, {FRAC_D{1'b0}}};
    b_sum   = $signed({2'b00, a_prod_r}) + b_mind;
    b_keep  = a_valid_r && a_pass_r && !b_sum[SUM_W-1] && (b_sum != '0);
    b_mag_x = a_dx_r[DIFF_W-1] ? MAG_W'(-a_dx_r) : a_dx_r[MAG_W-1:0];
    b_mag_y = a_dy_r[DIFF_W-1] ? MAG_W'(-a_dy_r) : a_dy_r[MAG_W-1:0];
    b_fb    = (F_W+B_W)'(cfg.focal_length) * (F_W+B_W)'(cfg.baseline);
    b_xb    = (MAG_W+B_W)'(b_mag_x) * (MAG_W+B_W)'(cfg.baseline);
    b_yb    = (MAG_W+B_W)'(b_mag_y) * (MAG_W+B_W)'(cfg.baseline);

    b_op_nxt.num[LANE_Z] = NUM_W'({b_fb, {NUM_SHIFT{1'b0}}});
    b_op_nxt.num[LANE_X] = NUM_W'({b_xb, {NUM_SHIFT{1'b0}}});
    b_op_nxt.num[LANE_Y] = NUM_W'({b_yb, {NUM_SHIFT{1'b0}}});
    b_op_nxt.den         = b_sum[DEN_W-1:0];

    b_side_nxt.neg_x = a_dx_r[DIFF_W-1];
    b_side_nxt.neg_y = a_dy_r[DIFF_W-1];
    b_side_nxt.red   = a_red_r;
    b_side_nxt.green = a_green_r;
    b_side_nxt.blue  = a_blue_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= b_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op_r   <= b_op_nxt;
      b_side_r <= b_side_nxt;
    end
  end

  assign front_valid = b_valid_r;
  assign front_side  = b_side_r;
  assign front_op    = b_op_r;

endmodule

### rtl/drp_divider.sv
module drp_divider
  import drp_pkg::*;
(
  input  logic                         clk,
  input  logic                         adv,
  input  op_t                          op,
  output logic [LANES-1:0][Q_BITS-1:0] quo,
  output logic [LANES-1:0]             ovf
);

  // One register set per stage; every step stage after the entry stage settles one quotient bit.
  logic [DEN_W-1:0]             den_r [DIV_LAT];
  logic [LANES-1:0][DEN_W-1:0]  rem_r [DIV_LAT];
  logic [LANES-1:0][Q_BITS-1:0] low_r [DIV_LAT];
  logic [LANES-1:0][Q_BITS-1:0] q_r   [DIV_LAT];
  logic [LANES-1:0]             ovf_r [DIV_LAT];

  // Entry stage: a quotient of 2^31 or more saturates, so check the top bits
  // against the divisor and start the remainder from them.
  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= op.den;
      for (int l = 0; l < LANES; l++) begin
        ovf_r[0][l] <= DEN_W'(op.num[l][NUM_W-1:Q_BITS]) >= op.den;
        rem_r[0][l] <= DEN_W'(op.num[l][NUM_W-1:Q_BITS]);
        low_r[0][l] <= op.num[l][Q_BITS-1:0];
        q_r[0][l]   <= '0;
      end
    end
  end

  // Restoring long-division steps.
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [LANES-1:0][DEN_W:0] trial;
    logic [LANES-1:0][DEN_W:0] diff;
    logic [LANES-1:0]          ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_r[k-1][l], low_r[k-1][l][Q_BITS-1]};
        diff[l]  = trial[l] - {1'b0, den_r[k-1]};
        ge[l]    = trial[l] >= {1'b0, den_r[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
          low_r[k][l] <= {low_r[k-1][l][Q_BITS-2:0], 1'b0};
          q_r[k][l]   <= {q_r[k-1][l][Q_BITS-2:0], ge[l]};
        end
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];
  assign ovf = ovf_r[DIV_LAT-1];

endmodule

### rtl/disparity_to_point_reprojection.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  pixel_row, pixel_col, disparity_raw, red, green, blue
// out_     output     out_valid/out_stall  point_x, point_y, point_z, point_red/green/blue
// cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One item is accepted every cycle while the result side keeps up.
// A kept item passes through two front stages, 32 stages of the pipelined
// divider (an entry stage, then one quotient bit per stage) and the output
// register. Dropped pixels leave bubbles and give no result.
// Reset is synchronous, clears all valid bits and sets the configuration registers to defaults.
// A stall on a full output register holds the whole pipeline, and in_stall is raised with it.
module disparity_to_point_reprojection
  import drp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ROW_W-1:0]     in_pixel_row,
  input  logic [COL_W-1:0]     in_pixel_col,
  input  logic [RAW_W-1:0]     in_disparity_raw,
  input  logic [COLOR_W-1:0]   in_red,
  input  logic [COLOR_W-1:0]   in_green,
  input  logic [COLOR_W-1:0]   in_blue,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_point_x,
  output logic [OUT_W-1:0]     out_point_y,
  output logic [Z_W-1:0]       out_point_z,
  output logic [COLOR_W-1:0]   out_point_red,
  output logic [COLOR_W-1:0]   out_point_green,
  output logic [COLOR_W-1:0]   out_point_blue
);

  cfg_t cfg_r;

  logic  adv;
  logic  front_valid;
  side_t front_side;
  op_t   front_op;

  logic [LANES-1:0][Q_BITS-1:0] div_quo;
  logic [LANES-1:0]             div_ovf;

  logic  vld_r  [DIV_LAT];
  side_t side_r [DIV_LAT];

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_x_r;
  logic [OUT_W-1:0]   out_y_r;
  logic [Z_W-1:0]     out_z_r;
  logic [COLOR_W-1:0] out_red_r;
  logic [COLOR_W-1:0] out_green_r;
  logic [COLOR_W-1:0] out_blue_r;

  logic [OUT_W-1:0]   out_x_nxt;
  logic [OUT_W-1:0]   out_y_nxt;
  logic [Z_W-1:0]     out_z_nxt;
  side_t              last_side;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_length    <= RST_FOCAL;
      cfg_r.baseline        <= RST_BASELINE;
      cfg_r.center_col      <= RST_CCOL;
      cfg_r.center_row      <= RST_CROW;
      cfg_r.disparity_scale <= RST_SCALE;
      cfg_r.min_disparity   <= RST_MIND;
      cfg_r.invalid_code    <= RST_INVALID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FOCAL:    cfg_r.focal_length    <= cfg_wdata[F_W-1:0];
        CFG_BASELINE: cfg_r.baseline        <= cfg_wdata[B_W-1:0];
        CFG_CCOL:     cfg_r.center_col      <= cfg_wdata[C_W-1:0];
        CFG_CROW:     cfg_r.center_row      <= cfg_wdata[C_W-1:0];
        CFG_SCALE:    cfg_r.disparity_scale <= cfg_wdata[SCALE_W-1:0];
        CFG_MIND:     cfg_r.min_disparity   <= cfg_wdata[MIND_W-1:0];
        CFG_INVALID:  cfg_r.invalid_code    <= cfg_wdata[INV_W-1:0];
        default:      cfg_r                 <= cfg_r;
      endcase
    end
  end

  drp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (in_valid),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_col     (in_pixel_col),
    .in_disparity_raw (in_disparity_raw),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .cfg              (cfg_r),
    .front_valid      (front_valid),
    .front_side       (front_side),
    .front_op         (front_op)
  );

  drp_divider u_divider (
    .clk (clk),
    .adv (adv),
    .op  (front_op),
    .quo (div_quo),
    .ovf (div_ovf)
  );

  // Valid bits and colors travel in step with the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= front_valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= front_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Apply signs and saturate the quotients.
  always_comb begin
    last_side = side_r[DIV_LAT-1];
    out_z_nxt = div_ovf[LANE_Z] ? {Z_W{1'b1}} : div_quo[LANE_Z];
    if (div_ovf[LANE_X]) begin
      out_x_nxt = last_side.neg_x ? SAT_NEG : SAT_POS;
    end else begin
      out_x_nxt = last_side.neg_x ? OUT_W'(-{1'b0, div_quo[LANE_X]})
                                  : {1'b0, div_quo[LANE_X]};
    end
    if (div_ovf[LANE_Y]) begin
      out_y_nxt = last_side.neg_y ? SAT_NEG : SAT_POS;
    end else begin
      out_y_nxt = last_side.neg_y ? OUT_W'(-{1'b0, div_quo[LANE_Y]})
                                  : {1'b0, div_quo[LANE_Y]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      out_z_r     <= out_z_nxt;
      out_red_r   <= last_side.red;
      out_green_r <= last_side.green;
      out_blue_r  <= last_side.blue;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_z     = out_z_r;
  assign out_point_red   = out_red_r;
  assign out_point_green = out_green_r;
  assign out_point_blue  = out_blue_r;

`ifndef ASSERT_OFF
  // A held pipeline keeps its last-stage valid bit.
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r[DIV_LAT-1]))
    else $error("divider valid bit moved during a stall");

  // A pixel kept by the front stages always has a nonzero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid |-> (front_op.den != '0))
    else $error("kept pixel with zero disparity");

  // Reset leaves the output register empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule
